// ===== src/windowed_gaussian_smoother_top_macros.svh =====
// Assertion macros for the windowed Gaussian smoother.
// Used by the controller; expects clk and rst_n in scope.
`ifndef WINDOWED_GAUSSIAN_SMOOTHER_TOP_MACROS_SVH
`define WINDOWED_GAUSSIAN_SMOOTHER_TOP_MACROS_SVH

// same-cycle implication
`define WGS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/wgs_pkg.sv =====
// Package for the windowed Gaussian smoother: sizes, register indexes,
// controller/datapath command types and the weight ROMs built at elaboration.
package wgs_pkg;

  localparam int WINDOW_MAX   = 16;
  localparam int VECTOR_LEN   = 4;
  localparam int SAMPLE_WIDTH = 16;
  localparam int DEPTH        = WINDOW_MAX - 1;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_MAX);
  localparam int WS_W         = 5;
  localparam int WEIGHT_W     = 17;
  localparam int PROD_W       = WEIGHT_W + 1 + SAMPLE_WIDTH;
  localparam int ACC_W        = PROD_W + CNT_W;
  localparam int FRAC_W       = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;
  localparam int WS_RESET     = 10;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_TYPE = 2'd1;

  localparam int TAB_SIZE = WINDOW_MAX * WINDOW_MAX;

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef weight_t gtab_t [TAB_SIZE];
  typedef weight_t atab_t [WINDOW_MAX];
  typedef logic [VECTOR_LEN-1:0][SAMPLE_WIDTH-1:0] vec_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0]  w_k;
    logic [CNT_W-1:0]  w_i;
    logic              ftype;
    logic              acc_clr;
    logic              out_load;
  } wgs_cmd_t;

  typedef struct packed {
    logic busy;
  } wgs_stat_t;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] gauss_raw(input int i, input int k);
    logic [63:0] one;
    logic [63:0] kk;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] t;
    one = 64'd1 << 30;
    kk  = 64'(k) * 64'(k);
    x   = udiv64(64'(i) * 64'(i) * 64'd150733 + (kk >> 1), kk);
    y   = x << 10;
    t   = one - udiv64(y, 64'd5);
    for (int d = 4; d >= 1; d--) begin
      t = one - udiv64((y * t) >> 30, 64'(d));
    end
    for (int s = 0; s < 4; s++) begin
      t = (t * t + (one >> 1)) >> 30;
    end
    return t;
  endfunction

  function automatic gtab_t build_gauss_tab();
    gtab_t       tab;
    logic [63:0] r [WINDOW_MAX];
    logic [63:0] sum;
    for (int n = 0; n < TAB_SIZE; n++) begin
      tab[n] = '0;
    end
    for (int k = 1; k < WINDOW_MAX; k++) begin
      sum = '0;
      for (int i = 0; i < k; i++) begin
        r[i] = gauss_raw(i, k);
        sum  = sum + r[i];
      end
      for (int i = 0; i < k; i++) begin
        tab[k * WINDOW_MAX + i] = WEIGHT_W'(udiv64((r[i] << 16) + (sum >> 1), sum));
      end
    end
    return tab;
  endfunction

  function automatic atab_t build_avg_tab();
    atab_t tab;
    tab[0] = '0;
    for (int k = 1; k < WINDOW_MAX; k++) begin
      tab[k] = WEIGHT_W'(udiv64(64'd65536 + 64'(k / 2), 64'(k)));
    end
    return tab;
  endfunction

  localparam gtab_t GAUSS_TAB = build_gauss_tab();
  localparam atab_t AVG_TAB   = build_avg_tab();

endpackage

// ===== src/windowed_gaussian_smoother_top.sv =====
// Windowed Gaussian smoother, top level.
// Input words carry four signed 16-bit components; each word is pushed into a
// sliding window of up to window_size-1 vectors (at most 15 kept) and yields one
// output word: the Gaussian- or uniform-weighted sum of the window, newest first,
// rounded half up and saturated to 16 bits.
// Channels: in_* and out_* use valid/stall; a word moves when valid is high and
// stall is low. cfg_* is a valid/ready write port: index 0 window_size, index 1
// filter_type. Write it only while no word is in flight.
// Timing: after a word is accepted, one multiply-accumulate per stored vector
// runs through the single-port sample memory, then the pipeline drains through
// its read, product and accumulator registers. Input stays stalled until the
// result is loaded; when window_size is below 2 no vector is read. The next word
// is accepted while the result still waits in its register.
// Stall on out_ holds the result; the next result waits until it is taken.
// Reset: empty window, window_size 10, Gaussian weights, no result pending.
module windowed_gaussian_smoother_top import wgs_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_0,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_1,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_2,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_3,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered_0,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered_1,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered_2,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered_3,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data
);

  wgs_cmd_t                       cmd;
  wgs_stat_t                      stat;
  vec_t                           wr_data;
  logic signed [SAMPLE_WIDTH-1:0] filt [VECTOR_LEN];

  assign wr_data = {in_sample_3, in_sample_2, in_sample_1, in_sample_0};

  wgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  wgs_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .stat    (stat),
    .wr_data (wr_data),
    .filt    (filt)
  );

  assign out_filtered_0 = filt[0];
  assign out_filtered_1 = filt[1];
  assign out_filtered_2 = filt[2];
  assign out_filtered_3 = filt[3];

endmodule

// ===== src/wgs_dp.sv =====
// Datapath of the windowed Gaussian smoother: sample memory, weight ROM,
// per-lane multiply-accumulate and rounded, saturated output words. Uses wgs_pkg.
module wgs_dp import wgs_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wgs_cmd_t                       cmd,
  output wgs_stat_t                      stat,
  input  vec_t                           wr_data,
  output logic signed [SAMPLE_WIDTH-1:0] filt [VECTOR_LEN]
);

  localparam int RND_W = ACC_W - FRAC_W;

  vec_t                           mem [DEPTH];
  vec_t                           rd_q_r;
  weight_t                        w_q_r;
  logic                           v1_r;
  logic                           v2_r;
  logic signed [PROD_W-1:0]       prod_r [VECTOR_LEN];
  logic signed [ACC_W-1:0]        acc_r  [VECTOR_LEN];
  logic signed [SAMPLE_WIDTH-1:0] filt_r [VECTOR_LEN];
  logic signed [SAMPLE_WIDTH-1:0] sat_nxt [VECTOR_LEN];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[cmd.rd_addr];
      w_q_r  <= cmd.ftype ? AVG_TAB[cmd.w_k] : GAUSS_TAB[{cmd.w_k, cmd.w_i}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
    end
  end

  assign stat.busy = v1_r | v2_r;

  always_ff @(posedge clk) begin
    for (int l = 0; l < VECTOR_LEN; l++) begin
      prod_r[l] <= $signed({1'b0, w_q_r}) * $signed(rd_q_r[l]);
      if (cmd.acc_clr) begin
        acc_r[l] <= '0;
      end else if (v2_r) begin
        acc_r[l] <= acc_r[l] + ACC_W'(prod_r[l]);
      end
      if (cmd.out_load) begin
        filt_r[l] <= sat_nxt[l];
      end
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] rnd;
    logic signed [RND_W-1:0] q;
    for (int l = 0; l < VECTOR_LEN; l++) begin
      rnd = acc_r[l] + ACC_W'(1 << (FRAC_W - 1));
      q   = RND_W'(rnd >>> FRAC_W);
      if (q > RND_W'((1 << (SAMPLE_WIDTH - 1)) - 1)) begin
        sat_nxt[l] = SAMPLE_WIDTH'((1 << (SAMPLE_WIDTH - 1)) - 1);
      end else if (q < -RND_W'(1 << (SAMPLE_WIDTH - 1))) begin
        sat_nxt[l] = SAMPLE_WIDTH'(1 << (SAMPLE_WIDTH - 1));
      end else begin
        sat_nxt[l] = SAMPLE_WIDTH'(q);
      end
    end
  end

  assign filt = filt_r;

endmodule

// ===== src/wgs_ctrl.sv =====
// Controller of the windowed Gaussian smoother: handshakes, configuration
// registers, window bookkeeping and the MAC sequencer. Uses wgs_pkg and the macro header.
`include "windowed_gaussian_smoother_top_macros.svh"

module wgs_ctrl import wgs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output wgs_cmd_t              cmd,
  input  wgs_stat_t             stat
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [ADDR_W-1:0] newest_r, newest_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [WS_W-1:0]   ws_r, ws_nxt;
  logic              ftype_r, ftype_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [WS_W-1:0]   lim;
  logic [CNT_W-1:0]  keep;
  logic [CNT_W:0]    fill_inc;
  logic [CNT_W-1:0]  fill_sat;
  logic [ADDR_W-1:0] newest_inc;
  logic [ADDR_W:0]   wrap_addr;
  logic              out_free;

  always_comb begin
    lim        = (ws_r > WS_W'(WINDOW_MAX)) ? WS_W'(WINDOW_MAX) : ws_r;
    keep       = (lim == '0) ? '0 : CNT_W'(lim - 1'b1);
    fill_inc   = {1'b0, fill_r} + 1'b1;
    fill_sat   = (fill_inc > {1'b0, keep}) ? keep : fill_inc[CNT_W-1:0];
    newest_inc = (newest_r == ADDR_W'(DEPTH - 1)) ? '0 : newest_r + 1'b1;
    wrap_addr  = {1'b0, newest_r} + (ADDR_W + 1)'(DEPTH) - {1'b0, idx_r};
    out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    newest_nxt    = newest_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.wr_addr   = newest_inc;
    cmd.rd_addr   = (newest_r >= idx_r) ? (newest_r - idx_r) : wrap_addr[ADDR_W-1:0];
    cmd.w_k       = fill_r;
    cmd.w_i       = idx_r;
    cmd.ftype     = ftype_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.wr_en   = 1'b1;
          cmd.acc_clr = 1'b1;
          newest_nxt  = newest_inc;
          fill_nxt    = fill_sat;
          idx_nxt     = '0;
          state_nxt   = (fill_sat == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.rd_en = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == CNT_W'(fill_r - 1'b1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.busy && out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign cfg_ready = (state_r == ST_IDLE);

  always_comb begin
    ws_nxt    = ws_r;
    ftype_nxt = ftype_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_SIZE: ws_nxt    = cfg_data[WS_W-1:0];
        REG_FILTER_TYPE: ftype_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      newest_r    <= '0;
      idx_r       <= '0;
      ws_r        <= WS_W'(WS_RESET);
      ftype_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      newest_r    <= newest_nxt;
      idx_r       <= idx_nxt;
      ws_r        <= ws_nxt;
      ftype_r     <= ftype_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  `WGS_ASSERT_NEXT(a_accept_blocks, in_valid && !in_stall, in_stall, "accept did not start work")
  `WGS_ASSERT_NOW(a_read_in_fill, cmd.rd_en, idx_r < fill_r, "read beyond fill")
  `WGS_ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid_r && state_r == ST_IDLE, "load lost")
  `WGS_ASSERT_NOW(a_load_free, cmd.out_load, !stat.busy && !(out_valid_r && out_stall), "overrun")

endmodule
